>>> rtl/lif_neuron_array_update_macros.svh
// Assertion helpers used by the checker file.
`ifndef LIF_NEURON_ARRAY_UPDATE_MACROS_SVH
`define LIF_NEURON_ARRAY_UPDATE_MACROS_SVH

`define LNAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lnau: assertion failed");

// Clocked on clk_i, disabled while rst_ni is low.
`define LNAU_ASSERT_CK(lbl, prop) \
  `LNAU_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/lnau_pkg.sv
`timescale 1ns / 1ps
package lnau_pkg;

  localparam int unsigned NEURON_COUNT_DEF = 1024;
  localparam int unsigned NEURON_W         = 10;
  localparam int unsigned POT_W            = 16;
  localparam int unsigned REFR_W           = 8;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [15:0] LEAK_RST   = 16'd62259;
  localparam logic [14:0] THRESH_RST = 15'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAK_FACTOR       = 3'd0,
    CFG_FIRE_THRESHOLD    = 3'd1,
    CFG_RESET_POTENTIAL   = 3'd2,
    CFG_REFRACTORY_PERIOD = 3'd3,
    CFG_SOURCE_NODE_ID    = 3'd4,
    CFG_SOURCE_CORE_ID    = 3'd5
  } lnau_cfg_idx_e;

  typedef struct packed {
    logic [31:0]         step_index;
    logic [NEURON_W-1:0] neuron_index;
    logic signed [15:0]  input_current;
  } lnau_in_t;

  typedef struct packed {
    logic [31:0]         spike_step;
    logic [NEURON_W-1:0] spike_neuron;
    logic [15:0]         spike_node;
    logic [15:0]         spike_core;
    logic [31:0]         spike_sequence;
  } lnau_spike_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } lnau_cfg_t;

endpackage

>>> rtl/lnau_stream_if.sv
`timescale 1ns / 1ps
interface lnau_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lnau_ram.sv
`timescale 1ns / 1ps
module lnau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // read during write to the same entry returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> rtl/lif_neuron_array_update.sv
`timescale 1ns / 1ps
// Leaky integrate-and-fire update for an array of neurons. Each item on in_ch
// with an index below NEURON_COUNT updates one neuron; a neuron that is not
// refractory and reaches the threshold puts one spike item on out_ch. Membrane
// potential and refractory count share one RAM word per neuron: the item's
// entry is read in the cycle it is accepted and the new word is written back
// when s1 advances, with the last write forwarded to a read of that neuron.
// One item per cycle while out_ch is ready; a spike passes stage s1 and out_q.
// After reset the RAM is cleared one entry per cycle (NEURON_COUNT entries,
// capped at 1024); in_ch is not ready until then. cfg_ch is always ready.
module lif_neuron_array_update
  import lnau_pkg::*;
#(
  parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  lnau_stream_if.sink   in_ch,
  lnau_stream_if.source out_ch,
  lnau_stream_if.sink   cfg_ch
);
  localparam int unsigned IDX_RANGE = 1 << NEURON_W;
  localparam int unsigned DEPTH = (NEURON_COUNT > IDX_RANGE) ? IDX_RANGE : NEURON_COUNT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MEM_W = REFR_W + POT_W;

  logic [15:0]       leak_q;
  logic [14:0]       thresh_q;
  logic [15:0]       rst_pot_q;
  logic [REFR_W-1:0] refr_q;
  logic [15:0]       node_q;
  logic [15:0]       core_q;

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  logic                s1_valid_q;
  logic [NEURON_W-1:0] s1_nidx_q;
  logic [31:0]         s1_step_q;
  logic signed [15:0]  s1_cur_q;

  logic             fwd_valid_q;
  logic [AW-1:0]    fwd_addr_q;
  logic [MEM_W-1:0] fwd_data_q;

  logic        out_valid_q;
  lnau_spike_t out_q;
  logic [31:0] seq_q;

  logic             s1_adv, acc, in_range, wr, fire;
  logic [AW-1:0]    s1_addr;
  logic [MEM_W-1:0] rdata, cur_word, new_word;
  logic signed [15:0] v, sat;
  logic [REFR_W-1:0]  rc;
  logic signed [32:0] prod;
  logic signed [33:0] rnd;
  logic signed [18:0] sum;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  assign s1_adv       = !out_valid_q || out_ch.ready;
  assign in_ch.ready  = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign acc          = in_ch.valid && in_ch.ready;
  assign in_range     = 32'(in_ch.data.neuron_index) < 32'(NEURON_COUNT);
  assign s1_addr      = s1_nidx_q[AW-1:0];
  assign wr           = s1_valid_q && s1_adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  always_comb begin
    cur_word = (fwd_valid_q && fwd_addr_q == s1_addr) ? fwd_data_q : rdata;
    v        = $signed(cur_word[POT_W-1:0]);
    rc       = cur_word[MEM_W-1:POT_W];
    prod     = $signed({{17{v[15]}}, v}) * $signed({17'b0, leak_q});
    rnd      = $signed({prod[32], prod}) + 34'sd32768;
    sum      = $signed({rnd[33], rnd[33:16]}) + $signed({{3{s1_cur_q[15]}}, s1_cur_q});
    if (sum > 19'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
    fire = (rc == '0) && ($signed({sat[15], sat}) >= $signed({2'b0, thresh_q}));
    if (rc != '0) begin
      new_word = {rc - 1'b1, rst_pot_q};
    end else if (fire) begin
      new_word = {refr_q, rst_pot_q};
    end else begin
      new_word = {rc, sat};
    end
    mem_we    = clr_busy_q || wr;
    mem_waddr = clr_busy_q ? clr_addr_q : s1_addr;
    mem_wdata = clr_busy_q ? '0 : new_word;
  end

  lnau_ram #(
    .WIDTH(MEM_W),
    .DEPTH(DEPTH)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (acc),
    .raddr_i(in_ch.data.neuron_index[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q    <= LEAK_RST;
      thresh_q  <= THRESH_RST;
      rst_pot_q <= '0;
      refr_q    <= '0;
      node_q    <= '0;
      core_q    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (lnau_cfg_idx_e'(cfg_ch.data.index))
        CFG_LEAK_FACTOR:       leak_q    <= cfg_ch.data.data;
        CFG_FIRE_THRESHOLD:    thresh_q  <= cfg_ch.data.data[14:0];
        CFG_RESET_POTENTIAL:   rst_pot_q <= cfg_ch.data.data;
        CFG_REFRACTORY_PERIOD: refr_q    <= cfg_ch.data.data[REFR_W-1:0];
        CFG_SOURCE_NODE_ID:    node_q    <= cfg_ch.data.data;
        CFG_SOURCE_CORE_ID:    core_q    <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_ch.ready) begin
        s1_valid_q <= acc && in_range;
      end
      if (wr) begin
        fwd_valid_q <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && fire;
      end
      if (wr && fire) begin
        seq_q <= seq_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_nidx_q <= in_ch.data.neuron_index;
      s1_step_q <= in_ch.data.step_index;
      s1_cur_q  <= in_ch.data.input_current;
    end
    if (wr) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= new_word;
    end
    if (wr && fire) begin
      out_q.spike_step     <= s1_step_q + 32'd1;
      out_q.spike_neuron   <= s1_nidx_q;
      out_q.spike_node     <= node_q;
      out_q.spike_core     <= core_q;
      out_q.spike_sequence <= seq_q;
    end
  end
endmodule

>>> rtl/lnau_chk.sv
`timescale 1ns / 1ps
`include "lif_neuron_array_update_macros.svh"
module lnau_chk
  import lnau_pkg::*;
#(
  parameter int unsigned NEURON_COUNT = NEURON_COUNT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input lnau_spike_t out_data_i
);
  logic        any_in_q;
  logic        seen_q;
  logic [31:0] last_seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_in_q   <= 1'b0;
      seen_q     <= 1'b0;
      last_seq_q <= '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        any_in_q <= 1'b1;
      end
      if (out_valid_i && out_ready_i) begin
        seen_q     <= 1'b1;
        last_seq_q <= out_data_i.spike_sequence;
      end
    end
  end

  `LNAU_ASSERT_CK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
  `LNAU_ASSERT_CK(a_seq_step, out_valid_i && out_ready_i && seen_q |-> out_data_i.spike_sequence == last_seq_q + 32'd1)
  `LNAU_ASSERT_CK(a_out_cause, out_valid_i |-> any_in_q)
  `LNAU_ASSERT_CK(a_neuron_range, out_valid_i |-> 32'(out_data_i.spike_neuron) < 32'(NEURON_COUNT))
endmodule

bind lif_neuron_array_update lnau_chk #(
  .NEURON_COUNT(NEURON_COUNT)
) u_lnau_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_ch.valid),
  .in_ready_i (in_ch.ready),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .out_data_i (out_ch.data)
);
